// ===== hw/rtl/qrv_pkg.sv =====
package qrv_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_TIME_STEP = 2'd0,
    REG_INERTIA_X = 2'd1,
    REG_INERTIA_Y = 2'd2,
    REG_INERTIA_Z = 2'd3
  } reg_idx_t;

  // One particle in
  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] omega_x;
    logic signed [31:0] omega_y;
    logic signed [31:0] omega_z;
    logic signed [31:0] torque_x;
    logic signed [31:0] torque_y;
    logic signed [31:0] torque_z;
    logic               fixed_flag;
  } in_item_t;

  // One particle out
  typedef struct packed {
    logic signed [31:0] new_quat_w;
    logic signed [31:0] new_quat_x;
    logic signed [31:0] new_quat_y;
    logic signed [31:0] new_quat_z;
    logic signed [31:0] new_omega_x;
    logic signed [31:0] new_omega_y;
    logic signed [31:0] new_omega_z;
    logic               root_clamped;
  } out_item_t;

  // Register write
  typedef struct packed {
    reg_idx_t    index;
    logic [31:0] value;
  } cfg_item_t;

endpackage

// ===== hw/rtl/qrv_stream_if.sv =====
interface qrv_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/quaternion_rotation_verlet_step.sv =====
// Rotational velocity-Verlet step for rigid particles held as quaternions. One particle item
// enters per clock while particle.ready is high, each giving exactly one result; the pipeline is
// built around eight 3-stage 64x64 multiplier passes, the 16-stage inertia divider (four
// quotient bits per stage) and the 12-stage square root (four root bits per stage). particle.ready
// falls only while the output register holds an item that result does not take, and then the
// whole pipeline holds. cfg is always ready; write registers only while no item is in flight.
module quaternion_rotation_verlet_step (
  input  logic         clk,
  input  logic         rst,
  qrv_stream_if.sink   particle,
  qrv_stream_if.source result,
  qrv_stream_if.sink   cfg
);
  import qrv_pkg::*;

  typedef logic signed [63:0] fx_t;

  localparam int NM     = 20;   // multiplier slots per pass
  localparam int DIV_ST = 16;
  localparam int SQ_ST  = 12;
  localparam int S_A    = 0;
  localparam int S_B    = 3;
  localparam int S_C    = 6;
  localparam int S_DIV  = 7;
  localparam int S_D    = S_DIV + DIV_ST;
  localparam int S_E    = S_D + 3;
  localparam int S_F    = S_E + 3;
  localparam int S_G    = S_F + 3;
  localparam int S_H    = S_G + 3;
  localparam int S_I    = S_H + 3;
  localparam int S_SQ   = S_I + 1;
  localparam int S_J    = S_SQ + SQ_ST;
  localparam int S_K    = S_J + 3;
  localparam int NS     = S_K + 1;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_ONE = 64'sh0000_0001_0000_0000;

  // 0.5*E(q)*v: quaternion index and minus sign for each term
  localparam int QI [4][3] = '{'{1, 2, 3}, '{0, 3, 2}, '{3, 0, 1}, '{2, 1, 0}};
  localparam bit QN [4][3] = '{'{1, 1, 1}, '{0, 1, 0}, '{0, 0, 1}, '{1, 0, 0}};

  typedef struct packed {
    logic [31:0] ts;
    logic [31:0] ix;
    logic [31:0] iy;
    logic [31:0] iz;
  } cf_t;

  typedef struct {
    logic        fixed;
    fx_t         qv [4];
    fx_t         wv [3];
    fx_t         tv [3];
    fx_t         dsq;
    fx_t         qdot [4];
    fx_t         s1;
    fx_t         wacc [3];
    fx_t         qdd [4];
    fx_t         s1sq;
    fx_t         s1h;
    fx_t         s2;
    fx_t         s3;
    fx_t         inner [4];
    fx_t         nq [4];
    fx_t         acc;
    logic [31:0] ow [3];
    logic [31:0] drem [3];
    logic [63:0] dn [3];
    logic [63:0] dq [3];
    logic        dovf [3];
    logic        dzero [3];
    logic        dneg [3];
    logic        clamped;
    logic [51:0] srem;
    logic [47:0] sroot;
    logic [95:0] sv;
    logic [63:0] ma [NM];
    logic [63:0] mb [NM];
    logic        mn [NM];
    logic [63:0] pp [NM][4];
    fx_t         mr [NM];
    out_item_t   o;
  } st_t;

  // ---------------------------------------------------------------- arithmetic helpers

  function automatic logic [63:0] mag(fx_t x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  // saturating add, symmetric range
  function automatic fx_t sadd(fx_t a, fx_t b);
    logic signed [64:0] t;
    t = 65'(a) + 65'(b);
    if (t[64] != t[63]) return t[64] ? -FX_MAX : FX_MAX;
    if (t[63:0] == 64'h8000_0000_0000_0000) return -FX_MAX;
    return fx_t'(t[63:0]);
  endfunction

  // x*0.5 toward zero
  function automatic fx_t half(fx_t x);
    logic [63:0] m;
    m = mag(x) >> 1;
    return x[63] ? -fx_t'(m) : fx_t'(m);
  endfunction

  // down by sh bits toward zero, saturated to 32 bits
  function automatic logic [31:0] narrow(fx_t x, int sh);
    logic [63:0] m;
    m = mag(x) >> sh;
    if (x[63]) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      m = -m;
    end else if (m > 64'h7FFF_FFFF) begin
      m = 64'h7FFF_FFFF;
    end
    return m[31:0];
  endfunction

  function automatic fx_t f_dt(cf_t c);
    return fx_t'({24'b0, c.ts, 8'b0});
  endfunction

  function automatic fx_t f_hdt(cf_t c);
    return fx_t'({25'b0, c.ts, 7'b0});
  endfunction

  function automatic fx_t f_qdt(cf_t c);
    return fx_t'({26'b0, c.ts, 6'b0});
  endfunction

  function automatic logic [31:0] den(cf_t c, int l);
    if (l == 0) return c.ix;
    if (l == 1) return c.iy;
    return c.iz;
  endfunction

  function automatic st_t clr(st_t p);
    st_t s;
    s = p;
    for (int i = 0; i < NM; i++) begin
      s.ma[i] = '0;
      s.mb[i] = '0;
      s.mn[i] = 1'b0;
    end
    return s;
  endfunction

  function automatic st_t put(st_t p, int i, fx_t a, fx_t b);
    st_t s;
    s = p;
    s.ma[i] = mag(a);
    s.mb[i] = mag(b);
    s.mn[i] = a[63] ^ b[63];
    return s;
  endfunction

  // quaternion product term k from slots 3k..3k+2, before the 0.5
  function automatic fx_t hq(st_t p, int k);
    fx_t a;
    a = QN[k][0] ? -p.mr[3*k] : p.mr[3*k];
    for (int j = 1; j < 3; j++)
      a = sadd(a, QN[k][j] ? -p.mr[3*k+j] : p.mr[3*k+j]);
    return a;
  endfunction

  function automatic fx_t dot(st_t p, int base);
    fx_t a;
    a = p.mr[base];
    for (int i = 1; i < 4; i++) a = sadd(a, p.mr[base+i]);
    return a;
  endfunction

  // ---------------------------------------------------------------- multiplier passes

  function automatic st_t mul_pp(st_t p);
    st_t s;
    s = p;
    for (int i = 0; i < NM; i++) begin
      s.pp[i][0] = 64'(p.ma[i][31:0])  * 64'(p.mb[i][31:0]);
      s.pp[i][1] = 64'(p.ma[i][31:0])  * 64'(p.mb[i][63:32]);
      s.pp[i][2] = 64'(p.ma[i][63:32]) * 64'(p.mb[i][31:0]);
      s.pp[i][3] = 64'(p.ma[i][63:32]) * 64'(p.mb[i][63:32]);
    end
    return s;
  endfunction

  function automatic st_t mul_fin(st_t p);
    st_t          s;
    logic [127:0] pr;
    logic [63:0]  m;
    s = p;
    for (int i = 0; i < NM; i++) begin
      pr = {p.pp[i][3], 64'b0} + {32'b0, p.pp[i][1], 32'b0}
         + {32'b0, p.pp[i][2], 32'b0} + {64'b0, p.pp[i][0]};
      m = (|pr[127:95]) ? 64'(FX_MAX) : {1'b0, pr[94:32]};
      s.mr[i] = p.mn[i] ? -fx_t'(m) : fx_t'(m);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- step stages

  // operand widening, E(q)*w products, gyroscopic products, dt^2
  function automatic st_t prep_a(in_item_t d, cf_t c);
    st_t s;
    s = '{default: '0};
    s.fixed = d.fixed_flag;
    s.qv[0] = fx_t'({{30{d.quat_w[31]}}, d.quat_w, 2'b00});
    s.qv[1] = fx_t'({{30{d.quat_x[31]}}, d.quat_x, 2'b00});
    s.qv[2] = fx_t'({{30{d.quat_y[31]}}, d.quat_y, 2'b00});
    s.qv[3] = fx_t'({{30{d.quat_z[31]}}, d.quat_z, 2'b00});
    s.wv[0] = fx_t'({{16{d.omega_x[31]}}, d.omega_x, 16'b0});
    s.wv[1] = fx_t'({{16{d.omega_y[31]}}, d.omega_y, 16'b0});
    s.wv[2] = fx_t'({{16{d.omega_z[31]}}, d.omega_z, 16'b0});
    s.tv[0] = fx_t'({{16{d.torque_x[31]}}, d.torque_x, 16'b0});
    s.tv[1] = fx_t'({{16{d.torque_y[31]}}, d.torque_y, 16'b0});
    s.tv[2] = fx_t'({{16{d.torque_z[31]}}, d.torque_z, 16'b0});
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 3; j++)
        s = put(s, 3*k+j, s.qv[QI[k][j]], s.wv[j]);
    s = put(s, 12, s.wv[1], s.wv[2]);
    s = put(s, 13, s.wv[2], s.wv[0]);
    s = put(s, 14, s.wv[0], s.wv[1]);
    s = put(s, 15, f_dt(c), f_dt(c));
    return s;
  endfunction

  // qdot, |qdot|^2 terms, gyroscopic terms times inertia differences
  function automatic st_t prep_b(st_t p, cf_t c);
    st_t s;
    fx_t dd [3];
    s = clr(p);
    for (int k = 0; k < 4; k++) s.qdot[k] = half(hq(p, k));
    s.dsq = p.mr[15];
    dd[0] = (fx_t'({32'b0, c.iy}) - fx_t'({32'b0, c.iz})) <<< 16;
    dd[1] = (fx_t'({32'b0, c.iz}) - fx_t'({32'b0, c.ix})) <<< 16;
    dd[2] = (fx_t'({32'b0, c.ix}) - fx_t'({32'b0, c.iy})) <<< 16;
    for (int k = 0; k < 4; k++) s = put(s, k, s.qdot[k], s.qdot[k]);
    for (int l = 0; l < 3; l++) s = put(s, 4+l, p.mr[12+l], dd[l]);
    return s;
  endfunction

  // s1, Euler numerators, divider set-up
  function automatic st_t prep_c(st_t p, cf_t c);
    st_t         s;
    fx_t         num;
    logic [63:0] m;
    s = clr(p);
    s.s1 = dot(p, 0);
    for (int l = 0; l < 3; l++) begin
      num        = sadd(p.tv[l], p.mr[4+l]);
      m          = mag(num);
      s.drem[l]  = {16'b0, m[63:48]};
      s.dn[l]    = {m[47:0], 16'b0};
      s.dq[l]    = '0;
      s.dovf[l]  = {16'b0, m[63:48]} >= den(c, l);
      s.dzero[l] = (num == '0);
      s.dneg[l]  = num[63];
    end
    return s;
  endfunction

  // restoring division, four quotient bits per stage
  function automatic st_t div_step(st_t p, cf_t c);
    st_t         s;
    logic [32:0] t;
    s = p;
    for (int l = 0; l < 3; l++)
      for (int b = 0; b < 4; b++) begin
        t        = {s.drem[l], s.dn[l][63]};
        s.dn[l]  = s.dn[l] << 1;
        if (t >= {1'b0, den(c, l)}) begin
          s.drem[l] = 32'(t - {1'b0, den(c, l)});
          s.dq[l]   = {s.dq[l][62:0], 1'b1};
        end else begin
          s.drem[l] = t[31:0];
          s.dq[l]   = {s.dq[l][62:0], 1'b0};
        end
      end
    return s;
  endfunction

  // angular acceleration, E(q)*wd, q*s1, s1^2, dt/2*wd
  function automatic st_t prep_d(st_t p, cf_t c);
    st_t s;
    fx_t qm;
    s = clr(p);
    for (int l = 0; l < 3; l++) begin
      qm = fx_t'({1'b0, p.dq[l][62:0]});
      if (p.dzero[l])                   s.wacc[l] = '0;
      else if (p.dovf[l] || p.dq[l][63]) s.wacc[l] = p.dneg[l] ? -FX_MAX : FX_MAX;
      else                              s.wacc[l] = p.dneg[l] ? -qm : qm;
    end
    for (int k = 0; k < 4; k++)
      for (int j = 0; j < 3; j++)
        s = put(s, 3*k+j, p.qv[QI[k][j]], s.wacc[j]);
    for (int k = 0; k < 4; k++) s = put(s, 12+k, p.qv[k], p.s1);
    s = put(s, 16, p.s1, p.s1);
    for (int l = 0; l < 3; l++) s = put(s, 17+l, f_hdt(c), s.wacc[l]);
    return s;
  endfunction

  // qdd, new omega, dot products, dt/2*qdd, s1*dt^2/2
  function automatic st_t prep_e(st_t p, cf_t c);
    st_t s;
    s = clr(p);
    for (int k = 0; k < 4; k++) s.qdd[k] = sadd(half(hq(p, k)), -p.mr[12+k]);
    s.s1sq = p.mr[16];
    for (int l = 0; l < 3; l++) s.ow[l] = narrow(sadd(p.wv[l], p.mr[17+l]), 16);
    for (int k = 0; k < 4; k++) begin
      s = put(s, k,   p.qdot[k], s.qdd[k]);
      s = put(s, 4+k, s.qdd[k],  s.qdd[k]);
      s = put(s, 8+k, f_hdt(c),  s.qdd[k]);
    end
    s = put(s, 12, p.s1, half(p.dsq));
    return s;
  endfunction

  // s2, s3, innermost radicand term, dt*(qdot + dt/2*qdd)
  function automatic st_t prep_f(st_t p, cf_t c);
    st_t s;
    s = clr(p);
    s.s2  = dot(p, 0);
    s.s3  = dot(p, 4);
    s.s1h = p.mr[12];
    for (int k = 0; k < 4; k++) s.inner[k] = sadd(p.qdot[k], p.mr[8+k]);
    s = put(s, 0, f_qdt(c), sadd(s.s3, -p.s1sq));
    for (int k = 0; k < 4; k++) s = put(s, 1+k, f_dt(c), s.inner[k]);
    return s;
  endfunction

  function automatic st_t prep_g(st_t p, cf_t c);
    st_t s;
    s = clr(p);
    s.acc = sadd(p.s2, p.mr[0]);
    for (int k = 0; k < 4; k++) s.nq[k] = sadd(p.qv[k], p.mr[1+k]);
    s = put(s, 0, f_dt(c), s.acc);
    return s;
  endfunction

  function automatic st_t prep_h(st_t p);
    st_t s;
    s = clr(p);
    s.acc = sadd(p.s1, p.mr[0]);
    s = put(s, 0, p.dsq, s.acc);
    return s;
  endfunction

  // radicand, clamp, root set-up
  function automatic st_t prep_i(st_t p);
    st_t s;
    fx_t rad;
    s = p;
    rad       = sadd(FX_ONE, -p.mr[0]);
    s.clamped = rad[63];
    s.sv      = {(rad[63] ? 64'b0 : 64'(rad)), 32'b0};
    s.srem    = '0;
    s.sroot   = '0;
    return s;
  endfunction

  // digit-by-digit square root, four root bits per stage
  function automatic st_t sq_step(st_t p);
    st_t         s;
    logic [51:0] r2;
    logic [51:0] tr;
    s = p;
    for (int b = 0; b < 4; b++) begin
      r2   = {s.srem[49:0], s.sv[95:94]};
      s.sv = s.sv << 2;
      tr   = {2'b0, s.sroot, 2'b01};
      if (r2 >= tr) begin
        s.srem  = r2 - tr;
        s.sroot = {s.sroot[46:0], 1'b1};
      end else begin
        s.srem  = r2;
        s.sroot = {s.sroot[46:0], 1'b0};
      end
    end
    return s;
  endfunction

  // Lagrange factor times q
  function automatic st_t prep_j(st_t p);
    st_t s;
    fx_t lam;
    s = clr(p);
    lam = sadd(sadd(FX_ONE, -p.s1h), -fx_t'({16'b0, p.sroot}));
    for (int k = 0; k < 4; k++) s = put(s, k, lam, p.qv[k]);
    return s;
  endfunction

  // result item, fixed particles pass through
  function automatic st_t fin_k(st_t p);
    st_t s;
    s = p;
    if (p.fixed) begin
      s.o.new_quat_w   = p.qv[0][33:2];
      s.o.new_quat_x   = p.qv[1][33:2];
      s.o.new_quat_y   = p.qv[2][33:2];
      s.o.new_quat_z   = p.qv[3][33:2];
      s.o.new_omega_x  = p.wv[0][47:16];
      s.o.new_omega_y  = p.wv[1][47:16];
      s.o.new_omega_z  = p.wv[2][47:16];
      s.o.root_clamped = 1'b0;
    end else begin
      s.o.new_quat_w   = narrow(sadd(p.nq[0], -p.mr[0]), 2);
      s.o.new_quat_x   = narrow(sadd(p.nq[1], -p.mr[1]), 2);
      s.o.new_quat_y   = narrow(sadd(p.nq[2], -p.mr[2]), 2);
      s.o.new_quat_z   = narrow(sadd(p.nq[3], -p.mr[3]), 2);
      s.o.new_omega_x  = p.ow[0];
      s.o.new_omega_y  = p.ow[1];
      s.o.new_omega_z  = p.ow[2];
      s.o.root_clamped = p.clamped;
    end
    return s;
  endfunction

  function automatic bit is_pp(int k);
    return k == S_A+1 || k == S_B+1 || k == S_D+1 || k == S_E+1 ||
           k == S_F+1 || k == S_G+1 || k == S_H+1 || k == S_J+1;
  endfunction

  function automatic bit is_fin(int k);
    return k == S_A+2 || k == S_B+2 || k == S_D+2 || k == S_E+2 ||
           k == S_F+2 || k == S_G+2 || k == S_H+2 || k == S_J+2;
  endfunction

  function automatic st_t stage(int k, st_t p, cf_t c);
    st_t s;
    s = p;
    if (k == S_B)                                 s = prep_b(p, c);
    else if (k == S_C)                            s = prep_c(p, c);
    else if (k >= S_DIV && k < S_DIV + DIV_ST)    s = div_step(p, c);
    else if (k == S_D)                            s = prep_d(p, c);
    else if (k == S_E)                            s = prep_e(p, c);
    else if (k == S_F)                            s = prep_f(p, c);
    else if (k == S_G)                            s = prep_g(p, c);
    else if (k == S_H)                            s = prep_h(p);
    else if (k == S_I)                            s = prep_i(p);
    else if (k >= S_SQ && k < S_SQ + SQ_ST)       s = sq_step(p);
    else if (k == S_J)                            s = prep_j(p);
    else if (k == S_K)                            s = fin_k(p);
    else if (is_pp(k))                            s = mul_pp(p);
    else if (is_fin(k))                           s = mul_fin(p);
    return s;
  endfunction

  // ---------------------------------------------------------------- registers

  cf_t             cf;
  st_t             pipe [NS];
  st_t             nxt  [NS];
  logic [NS-1:0]   vld;
  logic            advance;

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cf.ts <= 32'd167772;
      cf.ix <= 32'd65536;
      cf.iy <= 32'd65536;
      cf.iz <= 32'd65536;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_TIME_STEP: cf.ts <= cfg.data.value;
        REG_INERTIA_X: cf.ix <= cfg.data.value;
        REG_INERTIA_Y: cf.iy <= cfg.data.value;
        REG_INERTIA_Z: cf.iz <= cfg.data.value;
        default:       cf.ts <= cf.ts;
      endcase
    end
  end

  // whole pipeline moves unless the output register is full and not taken
  assign advance        = !vld[NS-1] || result.ready;
  assign particle.ready = advance;
  assign result.valid   = vld[NS-1];
  assign result.data    = pipe[NS-1].o;

  always_comb begin
    nxt[0] = prep_a(particle.data, cf);
    for (int k = 1; k < NS; k++) nxt[k] = stage(k, pipe[k-1], cf);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NS-2:0], particle.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < NS; k++) pipe[k] <= nxt[k];
    end
  end

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    vld[S_I] && pipe[S_I].clamped |-> pipe[S_I].sv == '0)
    else $error("clamped radicand not zeroed");

  a_fixed_noclamp: assert property (@(posedge clk) disable iff (rst)
    result.valid && pipe[NS-1].fixed |-> !result.data.root_clamped)
    else $error("fixed particle flagged as clamped");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qrv_pkg::*;

  localparam longint FX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint FX_ONE  = 64'sh1_0000_0000;
  localparam longint FX_HALF = 64'sh8000_0000;
  localparam longint FX_QTR  = 64'sh4000_0000;
  localparam int     DRAIN   = 60;
  localparam int     LIMIT   = 500000;
  localparam int     N_RAND  = 1030;

  logic clk;
  logic rst;
  int   cycle_cnt;
  int   err_cnt;
  int   sent_cnt;
  int   rcvd_cnt;
  int   clamp_cnt;
  int   fixed_cnt;

  qrv_stream_if #(.T(in_item_t))  particle_if ();
  qrv_stream_if #(.T(out_item_t)) result_if ();
  qrv_stream_if #(.T(cfg_item_t)) cfg_if ();

  quaternion_rotation_verlet_step dut (
    .clk      (clk),
    .rst      (rst),
    .particle (particle_if.sink),
    .result   (result_if.source),
    .cfg      (cfg_if.sink)
  );

  // shadow registers and pending results
  logic [31:0] sh_dt, sh_ix, sh_iy, sh_iz;
  out_item_t   pending_q[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- fixed-point helpers (Q32.32, symmetric saturation) ----------------
  function automatic logic [63:0] mag64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint signed_of(logic [63:0] m, bit neg);
    if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > FX_MAX - b) return FX_MAX;
    if (b < 0 && a < -FX_MAX - b) return -FX_MAX;
    return a + b;
  endfunction

  function automatic longint sat_sub(longint a, longint b);
    return sat_add(a, -b);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
    if (p[127:64] >= 64'h8000_0000) return signed_of(64'h7FFF_FFFF_FFFF_FFFF, neg);
    return signed_of(p[95:32], neg);
  endfunction

  function automatic longint fx_div(longint num, logic [31:0] den);
    logic [63:0] m, qq, r;
    bit neg;
    m = mag64(num);
    neg = num < 0;
    if (den == 0) return num == 0 ? 0 : signed_of(64'h7FFF_FFFF_FFFF_FFFF, neg);
    qq = m / den;
    r = m % den;
    if (qq >= 64'h8000_0000_0000) return signed_of(64'h7FFF_FFFF_FFFF_FFFF, neg);
    return signed_of((qq << 16) + ((r << 16) / den), neg);
  endfunction

  // floor root of a non-negative Q32.32 value
  function automatic longint fx_sqrt(longint r);
    logic [127:0] tgt, sq;
    logic [63:0] s, c;
    tgt = {64'd0, r} << 32;
    s = 0;
    for (int b = 47; b >= 0; b--) begin
      c = s | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= tgt) s = c;
    end
    return longint'(s);
  endfunction

  // 0.5 * E(q) * v
  function automatic void half_qprod(input longint q[4], input longint v[3],
                                     output longint o[4]);
    longint t[4];
    t[0] = sat_sub(sat_sub(-fx_mul(q[1], v[0]), fx_mul(q[2], v[1])), fx_mul(q[3], v[2]));
    t[1] = sat_add(sat_sub(fx_mul(q[0], v[0]), fx_mul(q[3], v[1])), fx_mul(q[2], v[2]));
    t[2] = sat_sub(sat_add(fx_mul(q[3], v[0]), fx_mul(q[0], v[1])), fx_mul(q[1], v[2]));
    t[3] = sat_add(sat_add(-fx_mul(q[2], v[0]), fx_mul(q[1], v[1])), fx_mul(q[0], v[2]));
    for (int k = 0; k < 4; k++) o[k] = fx_mul(t[k], FX_HALF);
  endfunction

  function automatic longint dot_4(longint a[4], longint b[4]);
    longint s;
    s = 0;
    for (int k = 0; k < 4; k++) s = sat_add(s, fx_mul(a[k], b[k]));
    return s;
  endfunction

  // narrow to 32 bits, toward zero, saturating
  function automatic logic [31:0] to_word(longint x, int sh);
    logic [63:0] m;
    m = mag64(x) >> sh;
    if (x < 0) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return 32'(-longint'(m));
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return m[31:0];
  endfunction

  // one Verlet rotation step for one particle
  function automatic out_item_t verlet_step(in_item_t p);
    out_item_t o;
    longint q[4], w[3], tq[3], qd[4], qdd[4], wa[3], tmp[4];
    longint dt, hdt, qdt, dsq, hdsq, s1, s2, s3, rad, lam, dyz, dzx, dxy, nq;
    if (p.fixed_flag) begin
      o = '{p.quat_w, p.quat_x, p.quat_y, p.quat_z,
            p.omega_x, p.omega_y, p.omega_z, 1'b0};
      return o;
    end
    q = '{longint'(p.quat_w) * 4, longint'(p.quat_x) * 4,
          longint'(p.quat_y) * 4, longint'(p.quat_z) * 4};
    w = '{longint'(p.omega_x) * 65536, longint'(p.omega_y) * 65536,
          longint'(p.omega_z) * 65536};
    tq = '{longint'(p.torque_x) * 65536, longint'(p.torque_y) * 65536,
           longint'(p.torque_z) * 65536};
    dt = longint'({32'd0, sh_dt}) * 256;
    hdt = fx_mul(dt, FX_HALF);
    qdt = fx_mul(dt, FX_QTR);
    dsq = fx_mul(dt, dt);
    hdsq = fx_mul(dsq, FX_HALF);
    half_qprod(q, w, qd);
    dyz = (longint'({32'd0, sh_iy}) - longint'({32'd0, sh_iz})) * 65536;
    dzx = (longint'({32'd0, sh_iz}) - longint'({32'd0, sh_ix})) * 65536;
    dxy = (longint'({32'd0, sh_ix}) - longint'({32'd0, sh_iy})) * 65536;
    wa[0] = fx_div(sat_add(tq[0], fx_mul(fx_mul(w[1], w[2]), dyz)), sh_ix);
    wa[1] = fx_div(sat_add(tq[1], fx_mul(fx_mul(w[2], w[0]), dzx)), sh_iy);
    wa[2] = fx_div(sat_add(tq[2], fx_mul(fx_mul(w[0], w[1]), dxy)), sh_iz);
    s1 = dot_4(qd, qd);
    half_qprod(q, wa, tmp);
    for (int k = 0; k < 4; k++) qdd[k] = sat_sub(tmp[k], fx_mul(q[k], s1));
    s2 = dot_4(qd, qdd);
    s3 = dot_4(qdd, qdd);
    rad = sat_sub(FX_ONE, fx_mul(dsq, sat_add(s1, fx_mul(dt, sat_add(s2,
            fx_mul(qdt, sat_sub(s3, fx_mul(s1, s1))))))));
    o.root_clamped = rad < 0;
    if (rad < 0) rad = 0;
    lam = sat_sub(sat_sub(FX_ONE, fx_mul(s1, hdsq)), fx_sqrt(rad));
    for (int k = 0; k < 4; k++) begin
      nq = sat_add(q[k], fx_mul(dt, sat_add(qd[k], fx_mul(hdt, qdd[k]))));
      tmp[k] = sat_sub(nq, fx_mul(lam, q[k]));
    end
    o.new_quat_w = to_word(tmp[0], 2);
    o.new_quat_x = to_word(tmp[1], 2);
    o.new_quat_y = to_word(tmp[2], 2);
    o.new_quat_z = to_word(tmp[3], 2);
    o.new_omega_x = to_word(sat_add(w[0], fx_mul(hdt, wa[0])), 16);
    o.new_omega_y = to_word(sat_add(w[1], fx_mul(hdt, wa[1])), 16);
    o.new_omega_z = to_word(sat_add(w[2], fx_mul(hdt, wa[2])), 16);
    return o;
  endfunction

  // ---------------- drivers ----------------
  // item held until accepted; valid is left high for the caller to lower
  task automatic send_particle(in_item_t p, bit typed, out_item_t want);
    @(negedge clk);
    particle_if.valid <= 1'b1;
    particle_if.data  <= p;
    do @(posedge clk); while (!particle_if.ready);
    pending_q.push_back(typed ? want : verlet_step(p));
    sent_cnt++;
    if (p.fixed_flag) fixed_cnt++;
  endtask

  task automatic idle_particle(int n);
    if (n == 0) return;
    @(negedge clk);
    particle_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{idx, val};
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_TIME_STEP: sh_dt = val;
      REG_INERTIA_X: sh_ix = val;
      REG_INERTIA_Y: sh_iy = val;
      REG_INERTIA_Z: sh_iz = val;
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [31:0] dt, logic [31:0] ix, logic [31:0] iy,
                           logic [31:0] iz);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_INERTIA_X, ix);
    write_reg(REG_INERTIA_Y, iy);
    write_reg(REG_INERTIA_Z, iz);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // wait until every expected result is in, then let the pipe settle
  task automatic drain_results();
    @(negedge clk);
    particle_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // ---------------- result side ----------------
  // result ready steps through four stall patterns: always ready, random, periodic, mostly ready
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      case ((cycle_cnt / 300) % 4)
        0: result_if.ready <= 1'b1;
        1: result_if.ready <= ($urandom_range(0, 1) == 1);
        2: result_if.ready <= (cycle_cnt % 7) < 4;
        default: result_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    out_item_t got, want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = result_if.data;
      rcvd_cnt++;
      if (got.root_clamped) clamp_cnt++;
      if (pending_q.size() == 0) begin
        $error("unexpected result item");
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (got.new_quat_w !== want.new_quat_w) begin
          $error("new_quat_w exp %h got %h", want.new_quat_w, got.new_quat_w); err_cnt++;
        end
        if (got.new_quat_x !== want.new_quat_x) begin
          $error("new_quat_x exp %h got %h", want.new_quat_x, got.new_quat_x); err_cnt++;
        end
        if (got.new_quat_y !== want.new_quat_y) begin
          $error("new_quat_y exp %h got %h", want.new_quat_y, got.new_quat_y); err_cnt++;
        end
        if (got.new_quat_z !== want.new_quat_z) begin
          $error("new_quat_z exp %h got %h", want.new_quat_z, got.new_quat_z); err_cnt++;
        end
        if (got.new_omega_x !== want.new_omega_x) begin
          $error("new_omega_x exp %h got %h", want.new_omega_x, got.new_omega_x); err_cnt++;
        end
        if (got.new_omega_y !== want.new_omega_y) begin
          $error("new_omega_y exp %h got %h", want.new_omega_y, got.new_omega_y); err_cnt++;
        end
        if (got.new_omega_z !== want.new_omega_z) begin
          $error("new_omega_z exp %h got %h", want.new_omega_z, got.new_omega_z); err_cnt++;
        end
        if (got.root_clamped !== want.root_clamped) begin
          $error("root_clamped exp %b got %b", want.root_clamped, got.root_clamped);
          err_cnt++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } row_t;

  function automatic logic [31:0] rand_word(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h7FFF_FFFF)) - 32'sh4000_0000);
      default: return 32'($signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000);
    endcase
  endfunction

  // mostly near-unit quaternions and moderate rates, some raw words
  function automatic in_item_t rand_particle();
    in_item_t p;
    int qk, wk;
    qk = ($urandom_range(0, 9) == 0) ? 0 : 1;
    wk = ($urandom_range(0, 7) == 0) ? 0 : 2;
    p.quat_w = rand_word(qk);
    p.quat_x = rand_word(qk);
    p.quat_y = rand_word(qk);
    p.quat_z = rand_word(qk);
    p.omega_x = rand_word(wk);
    p.omega_y = rand_word(wk);
    p.omega_z = rand_word(wk);
    p.torque_x = rand_word(wk);
    p.torque_y = rand_word(wk);
    p.torque_z = rand_word(wk);
    p.fixed_flag = ($urandom_range(0, 7) == 0);
    return p;
  endfunction

  row_t dir_tab[$];

  function automatic row_t mk_row(logic [31:0] qw, logic [31:0] qx, logic [31:0] qy,
                                  logic [31:0] qz, logic [31:0] wv, logic [31:0] tv,
                                  bit fx);
    row_t r;
    r.stim = '{qw, qx, qy, qz, wv, wv, wv, tv, tv, tv, fx};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  initial begin
    row_t r;
    logic [31:0] cfgs[6][4];
    int burst;
    int n;
    cycle_cnt = 0; err_cnt = 0; sent_cnt = 0; rcvd_cnt = 0;
    clamp_cnt = 0; fixed_cnt = 0;
    sh_dt = 32'd167772; sh_ix = 32'd65536; sh_iy = 32'd65536; sh_iz = 32'd65536;
    particle_if.valid = 1'b0; particle_if.data = '0;
    cfg_if.valid = 1'b0; cfg_if.data = '0;
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // directed rows
    r = mk_row(0, 0, 0, 0, 0, 0, 1'b0);                      // all zero: result all zero
    r.typed = 1'b1;
    dir_tab.push_back(r);
    r = mk_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 1'b1);           // fixed particle passes through
    r.typed = 1'b1;
    r.want = '{r.stim.quat_w, r.stim.quat_x, r.stim.quat_y, r.stim.quat_z,
               r.stim.omega_x, r.stim.omega_y, r.stim.omega_z, 1'b0};
    dir_tab.push_back(r);
    r = mk_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    r.typed = 1'b1;
    r.want = '{r.stim.quat_w, r.stim.quat_x, r.stim.quat_y, r.stim.quat_z,
               r.stim.omega_x, r.stim.omega_y, r.stim.omega_z, 1'b0};
    dir_tab.push_back(r);
    dir_tab.push_back(mk_row(32'h4000_0000, 0, 0, 0, 32'h1_0000, 0, 1'b0));
    dir_tab.push_back(mk_row(32'h4000_0000, 0, 0, 0, 0, 32'h1_0000, 1'b0));
    dir_tab.push_back(mk_row(32'h2D41_3CCD, 32'h2D41_3CCD, 0, 0, 32'h3_0000,
                             32'hFFFE_0000, 1'b0));
    dir_tab.push_back(mk_row(32'h4000_0000, 0, 0, 0, 32'h7FFF_FFFF, 0, 1'b0)); // clamp
    dir_tab.push_back(mk_row(0, 32'h4000_0000, 0, 0, 32'h8000_0000, 0, 1'b0)); // clamp
    dir_tab.push_back(mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                             32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    dir_tab.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 1'b0));
    dir_tab.push_back(mk_row(32'h1000_0000, 32'hF000_0000, 32'h0800_0000, 0,
                             32'h0002_8000, 32'h7FFF_FFFF, 1'b0));   // non-unit, big torque
    dir_tab.push_back(mk_row(32'h4000_0000, 0, 0, 0, 32'hFFFF_0000, 32'h8000_0000, 1'b0));

    foreach (dir_tab[i]) send_particle(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    drain_results();

    // settings: typical, extremes of step and inertia, asymmetric body
    cfgs[0] = '{32'd167772, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000};
    cfgs[1] = '{32'd1, 32'd1, 32'd1, 32'd1};
    cfgs[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    cfgs[3] = '{32'h0100_0000, 32'h0000_8000, 32'h0004_0000, 32'd1};
    cfgs[4] = '{32'd16777, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000};
    cfgs[5] = '{32'd167772, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000};

    foreach (cfgs[c]) begin
      load_regs(cfgs[c][0], cfgs[c][1], cfgs[c][2], cfgs[c][3]);
      // untyped directed rows again under this setting, now checked by the predictor
      for (int i = 3; i < dir_tab.size(); i++) send_particle(dir_tab[i].stim, 1'b0, '0);
      n = 0;
      while (n < N_RAND / 6) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        for (int b = 0; b < burst && n < N_RAND / 6; b++) begin
          send_particle(rand_particle(), 1'b0, '0);
          n++;
        end
        idle_particle($urandom_range(0, 6));
      end
      drain_results();
    end

    $display("Sent %0d particles over %0d register settings; %0d fixed, %0d clamped roots.",
             sent_cnt, 7, fixed_cnt, clamp_cnt);
    $display("Received %0d results, %0d mismatches.", rcvd_cnt, err_cnt);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
